// ===== rtl/keypad_multi_safe_code_lock_top_defines.svh =====
// Assertion macros shared by the keypad lock RTL.
`ifndef KEYPAD_MULTI_SAFE_CODE_LOCK_TOP_DEFINES_SVH
`define KEYPAD_MULTI_SAFE_CODE_LOCK_TOP_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define KMSCL_CHECK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("keypad lock assertion failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define KMSCL_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keypad lock assertion failed");

`endif

// ===== rtl/kmscl_pkg.sv =====
// Package with modes, key codes and register indexes of the keypad lock.
package kmscl_pkg;
   localparam logic [2:0] MODE_INIT           = 3'd0;
   localparam logic [2:0] MODE_USER_LOCKED    = 3'd1;
   localparam logic [2:0] MODE_ADMIN_LOCKED   = 3'd2;
   localparam logic [2:0] MODE_ADMIN_UNLOCKED = 3'd3;
   localparam logic [2:0] MODE_SELECT         = 3'd4;
   localparam logic [2:0] MODE_OPEN           = 3'd5;
   localparam logic [2:0] MODE_EDIT           = 3'd6;
   localparam logic [2:0] MODE_LOCKOUT        = 3'd7;

   localparam logic [3:0] KEY_ONE    = 4'd1;
   localparam logic [3:0] KEY_TWO    = 4'd2;
   localparam logic [3:0] KEY_THREE  = 4'd3;
   localparam logic [3:0] KEY_STAR   = 4'd10;
   localparam logic [3:0] KEY_HASH   = 4'd11;
   localparam logic [3:0] KEY_LETTER = 4'd12;

   localparam logic [1:0] REG_MIN_LEN   = 2'd0;
   localparam logic [1:0] REG_MAX_LEN   = 2'd1;
   localparam logic [1:0] REG_LOCK_TICK = 2'd2;
   localparam logic [1:0] REG_MAX_FAIL  = 2'd3;

   localparam logic [6:0]  RST_MIN_LEN   = 7'd5;
   localparam logic [6:0]  RST_MAX_LEN   = 7'd50;
   localparam logic [15:0] RST_LOCK_TICK = 16'd10;
   localparam logic [3:0]  RST_MAX_FAIL  = 4'd3;
endpackage

// ===== rtl/kmscl_if.sv =====
// Valid/ready channel interfaces for the keypad lock.
interface kmscl_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [3:0] key_value;
   modport source (output valid, opcode, key_value, input ready);
   modport sink (input valid, opcode, key_value, output ready);
endinterface

interface kmscl_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic       error_flag;
   logic [1:0] selected_safe;
   logic [6:0] entry_length;
   modport source (output valid, mode, error_flag, selected_safe, entry_length,
                   input ready);
   modport sink (input valid, mode, error_flag, selected_safe, entry_length,
                 output ready);
endinterface

interface kmscl_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/keypad_multi_safe_code_lock_top.sv =====
// Top level of the keypad lock controller with admin and safe codes.
// The lock takes one beat per key press or time tick on req_ch and returns
// exactly one result beat on rsp_ch carrying the mode, an error flag, the
// selected safe and the number of digits held in the entry buffer.
// Configuration beats on csr_ch are always taken; they must only arrive while
// the lock is idle. Register index 0 is the minimum code length, 1 the maximum
// code length, 2 the lockout length in ticks and 3 the failure limit.
// Most items finish in the accepting cycle, so the result beat is offered in
// the next cycle and a new request can be taken every cycle while the receiver
// keeps up. An item that completes a code walks the entry memory and the code
// memory one digit per cycle through their read ports, and no new request is
// taken until the walk has ended. A length mismatch ends the compare before
// any digit is read. One item is in flight at a time. The result sits in an
// output register; a new item is accepted while it waits only if the receiver
// takes it in that same cycle, so a stalled receiver holds back the request
// side without losing anything.
// Reset returns to admin locked mode with no stored codes and the default
// register values. Memory contents are left as they are; only digits below a
// recorded length are ever read.
module keypad_multi_safe_code_lock_top
   import kmscl_pkg::*;
#(
   parameter int MAX_DIGITS = 64,
   parameter int NUM_SAFES  = 4
) (
   input logic         clock,
   input logic         reset,
   kmscl_req_if.sink   req_ch,
   kmscl_rsp_if.source rsp_ch,
   kmscl_csr_if.sink   csr_ch
);
`include "keypad_multi_safe_code_lock_top_defines.svh"

   localparam int SLOTS = NUM_SAFES + 1;
   localparam int CW    = $clog2(MAX_DIGITS + 1);
   localparam int EAW   = $clog2(MAX_DIGITS);
   localparam int CAW   = $clog2(SLOTS * MAX_DIGITS);
   localparam int LW    = (CW > 7) ? CW : 7;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOP = 2'd1;

   // Configuration registers.
   logic [6:0]  min_len_ff, max_len_ff;
   logic [15:0] lock_ticks_ff;
   logic [3:0]  max_fail_ff;

   // Control state.
   logic [1:0]    state_ff, state_in;
   logic [2:0]    cur_ff, cur_in, prev_ff, prev_in;
   logic [1:0]    safe_ff, safe_in;
   logic [3:0]    fail_ff, fail_in;
   logic [15:0]   lock_ff, lock_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] len_ff [SLOTS];
   logic [SLOTS-1:0] valid_ff;

   // Digit walk state.
   logic          store_ff, store_in;     // copy rather than compare
   logic          goback_ff, goback_in;   // after the copy, swap modes back
   logic [2:0]    slot_ff, slot_in;
   logic [2:0]    target_ff, target_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] widx_ff;
   logic          pend_ff, pend_in;
   logic          match_ff, match_in;

   // Memories.
   logic [3:0] ent_mem [MAX_DIGITS];
   logic [3:0] code_mem [SLOTS * MAX_DIGITS];
   logic [3:0] ent_rd_ff, code_rd_ff;
   logic [CAW-1:0] code_raddr, code_waddr;

   logic rsp_valid_ff;
   logic [2:0] rsp_mode_ff;
   logic rsp_err_ff;
   logic [1:0] rsp_safe_ff;
   logic [6:0] rsp_len_ff;

   logic accept, fin, err;
   logic ent_we, len_we, len_clr;
   logic [2:0] len_slot;
   logic [LW-1:0] cnt_w, limit_w;
   logic [3:0] key;
   logic [3:0] letter;
   logic letter_ok;
   logic [2:0] sslot;
   logic [3:0] fail_inc;
   logic [1:0] ent_res;  // 0 nothing, 1 complete, 2 cancelled

   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign key = req_ch.key_value;
   assign letter = key - KEY_LETTER;
   assign letter_ok = (key >= KEY_LETTER) && (32'(letter) < NUM_SAFES);
   assign sslot = 3'd1 + 3'(safe_ff);
   assign cnt_w = LW'(cnt_ff);
   assign limit_w = (LW'(max_len_ff) < LW'(MAX_DIGITS)) ? LW'(max_len_ff)
                                                         : LW'(MAX_DIGITS);
   assign fail_inc = fail_ff + 4'd1;

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      safe_in   = safe_ff;
      fail_in   = fail_ff;
      lock_in   = lock_ff;
      cnt_in    = cnt_ff;
      store_in  = store_ff;
      goback_in = goback_ff;
      slot_in   = slot_ff;
      target_in = target_ff;
      n_in      = n_ff;
      idx_in    = idx_ff;
      pend_in   = 1'b0;
      match_in  = match_ff;
      fin       = 1'b0;
      err       = 1'b0;
      ent_we    = 1'b0;
      len_we    = 1'b0;
      len_clr   = 1'b0;
      len_slot  = slot_ff;
      ent_res   = 2'd0;
      if (state_ff == S_IDLE) begin
         if (accept) begin
            fin = 1'b1;
            // Shared digit entry handling for the code entry modes.
            if (key == KEY_STAR) begin
               ent_res = 2'd2;
            end else if (key == KEY_HASH) begin
               if (cnt_w >= LW'(min_len_ff)) ent_res = 2'd1;
            end
            if (cur_ff == MODE_LOCKOUT) begin
               if (req_ch.opcode) begin
                  if (lock_ff <= 16'd1) begin
                     lock_in = '0;
                     prev_in = cur_ff;
                     cur_in  = prev_ff;
                  end else begin
                     lock_in = lock_ff - 16'd1;
                  end
               end
            end else if (cur_ff == MODE_INIT) begin
               prev_in = cur_ff;
               cur_in  = MODE_ADMIN_LOCKED;
            end else if (!req_ch.opcode) begin
               if (cur_ff == MODE_ADMIN_LOCKED || cur_ff == MODE_SELECT ||
                   cur_ff == MODE_EDIT) begin
                  if (key == KEY_STAR) begin
                     cnt_in = '0;
                  end else if (key == KEY_HASH) begin
                     if (ent_res != 2'd1) err = 1'b1;
                  end else if (key >= KEY_LETTER) begin
                     err = 1'b1;
                  end else if (cnt_w < limit_w) begin
                     ent_we = 1'b1;
                     cnt_in = cnt_ff + CW'(1);
                  end else begin
                     err = 1'b1;
                  end
               end
               unique case (cur_ff)
                  MODE_USER_LOCKED: begin
                     if (key == KEY_STAR) begin
                        prev_in = cur_ff;
                        cur_in  = MODE_ADMIN_LOCKED;
                     end else if (letter_ok) begin
                        safe_in = letter[1:0];
                        prev_in = cur_ff;
                        cur_in  = MODE_SELECT;
                     end else begin
                        err = 1'b1;
                     end
                  end
                  MODE_ADMIN_UNLOCKED: begin
                     if (key == KEY_STAR) begin
                        prev_in = cur_ff;
                        cur_in  = MODE_ADMIN_LOCKED;
                     end else if (key == KEY_ONE) begin
                        prev_in = cur_ff;
                        cur_in  = MODE_USER_LOCKED;
                     end else if (key == KEY_TWO) begin
                        // Accepted and ignored.
                     end else if (key == KEY_THREE) begin
                        prev_in = cur_ff;
                        cur_in  = MODE_EDIT;
                     end else if (letter_ok) begin
                        safe_in = letter[1:0];
                        prev_in = cur_ff;
                        cur_in  = MODE_OPEN;
                     end else begin
                        err = 1'b1;
                     end
                  end
                  MODE_OPEN: begin
                     if (key == KEY_STAR) begin
                        cur_in  = prev_ff;
                        prev_in = cur_ff;
                     end else if (key == KEY_ONE) begin
                        prev_in = cur_ff;
                        cur_in  = MODE_USER_LOCKED;
                     end else if (key == KEY_TWO) begin
                        len_clr  = 1'b1;
                        len_slot = sslot;
                        prev_in  = cur_ff;
                        cur_in   = MODE_USER_LOCKED;
                     end else if (key == KEY_THREE) begin
                        prev_in = cur_ff;
                        cur_in  = MODE_EDIT;
                     end else begin
                        err = 1'b1;
                     end
                  end
                  MODE_ADMIN_LOCKED, MODE_SELECT, MODE_EDIT: begin
                     if (ent_res == 2'd1) begin
                        fin       = 1'b0;
                        state_in  = S_LOOP;
                        n_in      = cnt_ff;
                        idx_in    = '0;
                        cnt_in    = '0;
                        goback_in = (cur_ff == MODE_EDIT);
                        if (cur_ff == MODE_ADMIN_LOCKED) begin
                           slot_in   = 3'd0;
                           target_in = MODE_ADMIN_UNLOCKED;
                        end else if (cur_ff == MODE_SELECT) begin
                           slot_in   = sslot;
                           target_in = MODE_OPEN;
                        end else begin
                           slot_in   = (prev_ff == MODE_OPEN) ? sslot : 3'd0;
                           target_in = MODE_EDIT;
                        end
                        if (cur_ff == MODE_EDIT) begin
                           store_in = 1'b1;
                           if (prev_ff != MODE_OPEN && prev_ff != MODE_ADMIN_UNLOCKED) begin
                              // Nowhere to store: drop the entry and go back.
                              fin      = 1'b1;
                              state_in = S_IDLE;
                              cur_in   = prev_ff;
                              prev_in  = cur_ff;
                           end
                        end else begin
                           store_in = !valid_ff[slot_in];
                        end
                        if (state_in == S_LOOP) begin
                           match_in = store_in || (len_ff[slot_in] == cnt_ff);
                           if (store_in) begin
                              len_we   = 1'b1;
                              len_slot = slot_in;
                           end
                        end
                     end else if (ent_res == 2'd2) begin
                        if (cur_ff == MODE_EDIT) begin
                           cur_in  = prev_ff;
                           prev_in = cur_ff;
                        end else if (cur_ff == MODE_SELECT || valid_ff[0]) begin
                           prev_in = cur_ff;
                           cur_in  = MODE_USER_LOCKED;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end else begin
         // Walk the digits: issue one read a cycle, use the data in the cycle after.
         if (idx_ff < n_ff && match_ff) begin
            pend_in = 1'b1;
            idx_in  = idx_ff + CW'(1);
         end
         if (pend_ff && !store_ff && ent_rd_ff != code_rd_ff) match_in = 1'b0;
         if (!pend_ff && (idx_ff == n_ff || !match_ff)) begin
            fin      = 1'b1;
            state_in = S_IDLE;
            if (store_ff && goback_ff) begin
               cur_in  = prev_ff;
               prev_in = cur_ff;
            end else if (match_ff) begin
               prev_in = cur_ff;
               cur_in  = target_ff;
            end else begin
               err = 1'b1;
               fail_in = fail_inc;
               if (fail_inc >= max_fail_ff) begin
                  fail_in = '0;
                  prev_in = cur_ff;
                  cur_in  = MODE_LOCKOUT;
                  lock_in = lock_ticks_ff;
               end
            end
         end
      end
   end

   assign code_raddr = CAW'(slot_ff) * CAW'(MAX_DIGITS) + CAW'(idx_ff);
   assign code_waddr = CAW'(slot_ff) * CAW'(MAX_DIGITS) + CAW'(widx_ff);

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[cnt_ff[EAW-1:0]] <= key;
      ent_rd_ff <= ent_mem[idx_ff[EAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LOOP && pend_ff && store_ff) code_mem[code_waddr] <= ent_rd_ff;
      code_rd_ff <= code_mem[code_raddr];
   end

   always_ff @(posedge clock) begin
      widx_ff <= idx_ff;
      if (reset) begin
         min_len_ff    <= RST_MIN_LEN;
         max_len_ff    <= RST_MAX_LEN;
         lock_ticks_ff <= RST_LOCK_TICK;
         max_fail_ff   <= RST_MAX_FAIL;
         state_ff      <= S_IDLE;
         cur_ff        <= MODE_ADMIN_LOCKED;
         prev_ff       <= MODE_INIT;
         safe_ff       <= '0;
         fail_ff       <= '0;
         lock_ff       <= '0;
         cnt_ff        <= '0;
         valid_ff      <= '0;
         for (int s = 0; s < SLOTS; s++) len_ff[s] <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               REG_MIN_LEN:   min_len_ff    <= csr_ch.data[6:0];
               REG_MAX_LEN:   max_len_ff    <= csr_ch.data[6:0];
               REG_LOCK_TICK: lock_ticks_ff <= csr_ch.data;
               REG_MAX_FAIL:  max_fail_ff   <= csr_ch.data[3:0];
               default: begin
               end
            endcase
         end
         state_ff <= state_in;
         cur_ff   <= cur_in;
         prev_ff  <= prev_in;
         safe_ff  <= safe_in;
         fail_ff  <= fail_in;
         lock_ff  <= lock_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         if (len_we) begin
            len_ff[len_slot]   <= cnt_ff;
            valid_ff[len_slot] <= 1'b1;
         end else if (len_clr) begin
            len_ff[len_slot]   <= '0;
            valid_ff[len_slot] <= 1'b0;
         end
         if (fin) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      store_ff  <= store_in;
      goback_ff <= goback_in;
      slot_ff   <= slot_in;
      target_ff <= target_in;
      n_ff      <= n_in;
      idx_ff    <= idx_in;
      match_ff  <= match_in;
      if (fin) begin
         rsp_mode_ff <= cur_in;
         rsp_err_ff  <= err;
         rsp_safe_ff <= safe_in;
         rsp_len_ff  <= 7'(cnt_in);
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.mode          = rsp_mode_ff;
   assign rsp_ch.error_flag    = rsp_err_ff;
   assign rsp_ch.selected_safe = rsp_safe_ff;
   assign rsp_ch.entry_length  = rsp_len_ff;

   `KMSCL_CHECK(a_no_accept_in_walk, (state_ff == S_LOOP) |-> !req_ch.ready)
   `KMSCL_CHECK(a_count_in_range, cnt_ff <= CW'(MAX_DIGITS))
   `KMSCL_CHECK(a_pending_only_in_walk, pend_ff |-> (state_ff == S_LOOP))
   `KMSCL_NEXT(a_accept_gives_result, accept && (state_in == S_IDLE), rsp_valid_ff)
endmodule

// ===== test/keypad_multi_safe_code_lock_checker.sv =====
// Checker for the keypad lock: predicts each result beat and compares it.
`timescale 1ns / 1ps

module keypad_multi_safe_code_lock_checker
   import kmscl_pkg::*;
(
   input logic  clock,
   input logic  reset,
   kmscl_req_if req,
   kmscl_rsp_if rsp,
   kmscl_csr_if csr,
   output int   fail_count,
   output int   pending_count
);
   localparam int DIGITS = 64;
   localparam int SAFES  = 4;
   localparam int SLOTS  = SAFES + 1;

   typedef struct packed {
      logic [2:0] mode;
      logic       error_flag;
      logic [1:0] selected_safe;
      logic [6:0] entry_length;
   } lock_result_t;

   typedef enum int {ENTRY_OPEN, ENTRY_DONE, ENTRY_CANCEL} entry_status_t;

   logic [6:0]  min_len, max_len;
   logic [15:0] lock_ticks;
   logic [3:0]  fail_limit;

   logic [2:0]  cur_mode, prev_mode;
   logic [1:0]  safe_sel;
   logic [3:0]  fail_cnt;
   int unsigned lock_left, digit_cnt;
   logic [3:0]  digit_buf [DIGITS];
   logic [3:0]  code_mem [SLOTS][DIGITS];
   int unsigned code_len [SLOTS];
   logic        code_set [SLOTS];
   bit          key_err;

   lock_result_t awaited_results[$];

   assign pending_count = awaited_results.size();

   function automatic void enter_mode(logic [2:0] m);
      prev_mode = cur_mode;
      cur_mode  = m;
   endfunction

   function automatic void return_mode();
      logic [2:0] t;
      t         = cur_mode;
      cur_mode  = prev_mode;
      prev_mode = t;
   endfunction

   function automatic entry_status_t collect_key(logic [3:0] key);
      int unsigned cap;
      cap = (max_len < DIGITS) ? max_len : DIGITS;
      if (key == KEY_STAR) begin
         digit_cnt = 0;
         return ENTRY_CANCEL;
      end
      if (key == KEY_HASH) begin
         if (digit_cnt >= min_len) return ENTRY_DONE;
         key_err = 1;
         return ENTRY_OPEN;
      end
      if (key >= KEY_LETTER) begin
         key_err = 1;
         return ENTRY_OPEN;
      end
      if (digit_cnt < cap) begin
         digit_buf[digit_cnt] = key;
         digit_cnt++;
      end else begin
         key_err = 1;
      end
      return ENTRY_OPEN;
   endfunction

   function automatic void save_code(int slot);
      for (int i = 0; i < digit_cnt; i++) code_mem[slot][i] = digit_buf[i];
      code_len[slot] = digit_cnt;
      code_set[slot] = 1;
      digit_cnt      = 0;
   endfunction

   function automatic void check_code(int slot, logic [2:0] target);
      bit match;
      match = (code_len[slot] == digit_cnt);
      for (int i = 0; i < digit_cnt; i++)
         if (match && code_mem[slot][i] != digit_buf[i]) match = 0;
      digit_cnt = 0;
      if (match) begin
         enter_mode(target);
         return;
      end
      key_err  = 1;
      fail_cnt = fail_cnt + 4'd1;
      if (fail_cnt >= fail_limit) begin
         fail_cnt = 0;
         enter_mode(MODE_LOCKOUT);
         lock_left = lock_ticks;
      end
   endfunction

   function automatic void pick_safe(logic [3:0] key, logic [2:0] target);
      if (key >= KEY_LETTER && key - KEY_LETTER < SAFES) begin
         safe_sel = 2'(key - KEY_LETTER);
         enter_mode(target);
      end else begin
         key_err = 1;
      end
   endfunction

   function automatic lock_result_t lock_response(logic tick, logic [3:0] key);
      entry_status_t st;
      int            slot;
      lock_result_t  r;
      key_err = 0;
      slot    = 1 + safe_sel;
      if (cur_mode == MODE_LOCKOUT) begin
         if (tick) begin
            if (lock_left <= 1) begin
               lock_left = 0;
               enter_mode(prev_mode);
            end else begin
               lock_left--;
            end
         end
      end else if (cur_mode == MODE_INIT) begin
         enter_mode(MODE_ADMIN_LOCKED);
      end else if (!tick) begin
         case (cur_mode)
            MODE_USER_LOCKED: begin
               if (key == KEY_STAR) enter_mode(MODE_ADMIN_LOCKED);
               else if (key <= KEY_HASH) key_err = 1;
               else pick_safe(key, MODE_SELECT);
            end
            MODE_ADMIN_LOCKED: begin
               st = collect_key(key);
               if (st == ENTRY_DONE) begin
                  if (code_set[0]) check_code(0, MODE_ADMIN_UNLOCKED);
                  else begin
                     save_code(0);
                     enter_mode(MODE_ADMIN_UNLOCKED);
                  end
               end else if (st == ENTRY_CANCEL && code_set[0]) begin
                  enter_mode(MODE_USER_LOCKED);
               end
            end
            MODE_ADMIN_UNLOCKED: begin
               if (key == KEY_STAR) enter_mode(MODE_ADMIN_LOCKED);
               else if (key == KEY_ONE) enter_mode(MODE_USER_LOCKED);
               else if (key == KEY_TWO) key_err = 0;
               else if (key == KEY_THREE) enter_mode(MODE_EDIT);
               else if (key >= KEY_LETTER) pick_safe(key, MODE_OPEN);
               else key_err = 1;
            end
            MODE_SELECT: begin
               st = collect_key(key);
               if (st == ENTRY_DONE) begin
                  if (code_set[slot]) check_code(slot, MODE_OPEN);
                  else begin
                     save_code(slot);
                     enter_mode(MODE_OPEN);
                  end
               end else if (st == ENTRY_CANCEL) begin
                  enter_mode(MODE_USER_LOCKED);
               end
            end
            MODE_OPEN: begin
               if (key == KEY_STAR) return_mode();
               else if (key == KEY_ONE) enter_mode(MODE_USER_LOCKED);
               else if (key == KEY_TWO) begin
                  code_set[slot] = 0;
                  code_len[slot] = 0;
                  enter_mode(MODE_USER_LOCKED);
               end
               else if (key == KEY_THREE) enter_mode(MODE_EDIT);
               else key_err = 1;
            end
            default: begin
               st = collect_key(key);
               if (st == ENTRY_DONE) begin
                  if (prev_mode == MODE_OPEN) save_code(slot);
                  else if (prev_mode == MODE_ADMIN_UNLOCKED) save_code(0);
                  else digit_cnt = 0;
                  return_mode();
               end else if (st == ENTRY_CANCEL) begin
                  return_mode();
               end
            end
         endcase
      end
      r.mode          = cur_mode;
      r.error_flag    = key_err;
      r.selected_safe = safe_sel;
      r.entry_length  = 7'(digit_cnt);
      return r;
   endfunction

   always @(posedge clock) begin
      lock_result_t seen, want;
      if (reset) begin
         min_len    = RST_MIN_LEN;
         max_len    = RST_MAX_LEN;
         lock_ticks = RST_LOCK_TICK;
         fail_limit = RST_MAX_FAIL;
         cur_mode   = MODE_ADMIN_LOCKED;
         prev_mode  = MODE_INIT;
         safe_sel   = 0;
         fail_cnt   = 0;
         lock_left  = 0;
         digit_cnt  = 0;
         for (int s = 0; s < SLOTS; s++) begin
            code_len[s] = 0;
            code_set[s] = 0;
         end
         awaited_results.delete();
         fail_count = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            seen = '{rsp.mode, rsp.error_flag, rsp.selected_safe, rsp.entry_length};
            if (awaited_results.size() == 0) begin
               $error("result beat with no item outstanding: %p", seen);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               if (seen.mode !== want.mode) begin
                  $error("mode: expected %0d, got %0d", want.mode, seen.mode);
                  fail_count++;
               end
               if (seen.error_flag !== want.error_flag) begin
                  $error("error_flag: expected %0d, got %0d", want.error_flag,
                         seen.error_flag);
                  fail_count++;
               end
               if (seen.selected_safe !== want.selected_safe) begin
                  $error("selected_safe: expected %0d, got %0d", want.selected_safe,
                         seen.selected_safe);
                  fail_count++;
               end
               if (seen.entry_length !== want.entry_length) begin
                  $error("entry_length: expected %0d, got %0d", want.entry_length,
                         seen.entry_length);
                  fail_count++;
               end
            end
         end
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_MIN_LEN:   min_len    = csr.data[6:0];
               REG_MAX_LEN:   max_len    = csr.data[6:0];
               REG_LOCK_TICK: lock_ticks = csr.data;
               default:       fail_limit = csr.data[3:0];
            endcase
         end
         if (req.valid && req.ready)
            awaited_results.push_back(lock_response(req.opcode, req.key_value));
      end
   end
endmodule

// ===== test/keypad_multi_safe_code_lock_top_test.sv =====
// Testbench top for the keypad lock: stimulus, handshakes and the verdict.
`timescale 1ns / 1ps

module keypad_multi_safe_code_lock_top_test;
   import kmscl_pkg::*;

   // A compare walks at most 64 digits, so any quiet stretch beyond
   // STUCK_LIMIT without a single beat means the block is stuck.
   localparam int STUCK_LIMIT = 5000;
   localparam int DIGITS      = 64;

   logic clock;
   logic reset;

   kmscl_req_if req_ch ();
   kmscl_rsp_if rsp_ch ();
   kmscl_csr_if csr_ch ();

   int fail_count;
   int pending_count;

   // Percentages of idle cycles on each side, changed from phase to phase.
   int send_idle_pct;
   int recv_stall_pct;

   // Bumping this asks the receiver process for one long hold-off.
   int hold_requests;
   int quiet_cycles;

   // A small pool of codes per slot, so that most entries hit a stored code
   // and the lock gets past its locked modes.
   logic [3:0] code_pool [5][DIGITS];
   int         pool_len [5];
   int         len_lo, len_hi;

   keypad_multi_safe_code_lock_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   keypad_multi_safe_code_lock_checker lock_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .csr           (csr_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      int seen_holds;
      int hold_left;
      seen_holds = 0;
      hold_left  = 0;
      rsp_ch.ready = 0;
      forever begin
         @(posedge clock);
         if (seen_holds != hold_requests) begin
            seen_holds = hold_requests;
            hold_left  = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: counts cycles in which no beat moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STUCK_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sends one item; the sender may first sit idle for a random stretch.
   task automatic send_item(logic op, logic [3:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid     <= 1;
      req_ch.opcode    <= op;
      req_ch.key_value <= key;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drops valid and waits until every predicted result has come back.
   task automatic drain();
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      csr_ch.valid <= 1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 0;
      @(posedge clock);
   endtask

   // Applies a register setting and draws fresh codes that fit its lengths.
   task automatic configure(int min_l, int max_l, int ticks, int fails);
      write_reg(REG_MIN_LEN, 16'(min_l));
      write_reg(REG_MAX_LEN, 16'(max_l));
      write_reg(REG_LOCK_TICK, 16'(ticks));
      write_reg(REG_MAX_FAIL, 16'(fails));
      len_hi = (max_l < DIGITS) ? max_l : DIGITS;
      len_lo = (min_l < 1) ? 1 : min_l;
      if (len_lo > len_hi) len_lo = len_hi;
      for (int s = 0; s < 5; s++) begin
         pool_len[s] = $urandom_range(len_hi, len_lo);
         if (pool_len[s] > 12 && $urandom_range(3) != 0) pool_len[s] = len_lo;
         for (int i = 0; i < DIGITS; i++) code_pool[s][i] = 4'($urandom_range(9));
      end
   endtask

   // One code entry: mostly a pooled code, sometimes random digits of a
   // length that may fall outside the limits, closed by hash or star or left open.
   task automatic enter_code(ref int sent);
      int         slot, n, pick;
      bit         pooled;
      slot   = $urandom_range(4);
      pooled = ($urandom_range(99) < 70);
      n      = pooled ? pool_len[slot] : $urandom_range(len_hi + 2, 0);
      if (!pooled && n > 12 && $urandom_range(3) != 0) n = len_lo;
      for (int i = 0; i < n; i++) begin
         send_item(0, pooled ? code_pool[slot][i] : 4'($urandom_range(9)));
         sent++;
      end
      pick = $urandom_range(99);
      if (pick < 85) begin
         send_item(0, KEY_HASH);
         sent++;
      end else if (pick < 95) begin
         send_item(0, KEY_STAR);
         sent++;
      end
   endtask

   // Random traffic until about the requested number of items have gone.
   task automatic random_traffic(int count);
      int sent, pick, n;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            enter_code(sent);
         end else if (pick < 65) begin
            send_item(0, 4'($urandom_range(15, 12)));
            sent++;
         end else if (pick < 80) begin
            case ($urandom_range(3))
               0: send_item(0, KEY_ONE);
               1: send_item(0, KEY_TWO);
               2: send_item(0, KEY_THREE);
               default: send_item(0, KEY_STAR);
            endcase
            sent++;
         end else if (pick < 92) begin
            // Runs of ticks carry the lock out of lockout.
            n = $urandom_range(6, 1);
            repeat (n) send_item(1, 4'($urandom_range(15)));
            sent += n;
         end else begin
            send_item(1'($urandom_range(1)), 4'($urandom_range(15)));
            sent++;
         end
      end
   endtask

   initial begin
      reset            = 1;
      req_ch.valid     = 0;
      req_ch.opcode    = 0;
      req_ch.key_value = 0;
      csr_ch.valid     = 0;
      csr_ch.index     = REG_MIN_LEN;
      csr_ch.data      = 0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      hold_requests    = 0;
      quiet_cycles     = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part at the reset settings. A tick outside lockout does
      // nothing, and hash with too few digits or a letter is rejected.
      send_item(1, 4'd15);
      send_item(0, KEY_HASH);
      send_item(0, 4'd13);
      // Star while no admin code exists just clears the entry.
      send_item(0, 4'd9);
      send_item(0, 4'd8);
      send_item(0, KEY_STAR);
      // The first admin entry becomes the admin code.
      for (int d = 1; d <= 5; d++) send_item(0, 4'(d));
      send_item(0, KEY_HASH);
      // Key two is accepted without effect, a digit is rejected, letter D
      // opens the last safe directly.
      send_item(0, KEY_TWO);
      send_item(0, 4'd7);
      send_item(0, 4'd15);
      // Edit the open safe's code, with the smallest and largest digit.
      send_item(0, KEY_THREE);
      send_item(0, 4'd0);
      send_item(0, 4'd6);
      send_item(0, 4'd6);
      send_item(0, 4'd6);
      send_item(0, 4'd9);
      send_item(0, KEY_HASH);
      send_item(0, KEY_ONE);
      drain();

      // Defaults kept, no idling on either side.
      configure(5, 50, 10, 3);
      random_traffic(350);
      drain();

      // Shortest codes, longest buffer, one failure locks out for one tick.
      send_idle_pct = 76;
      configure(1, 64, 1, 1);
      random_traffic(350);
      drain();

      // Longest minimum, a maximum above the buffer size is capped, a
      // lockout length of zero, and the highest failure limit.
      send_idle_pct  = 0;
      recv_stall_pct = 76;
      configure(64, 100, 0, 15);
      random_traffic(350);
      drain();

      // The longest lockout is written and then replaced, so that a run of
      // ticks in the next phase is enough to leave lockout.
      write_reg(REG_LOCK_TICK, 16'hFFFF);
      send_idle_pct  = 31;
      recv_stall_pct = 31;
      configure(3, 8, 4, 2);
      random_traffic(350);
      drain();

      // Pressure: the receiver holds off while items keep coming, then the
      // sender pauses until the block has emptied.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      configure(4, 6, 3, 2);
      hold_requests = hold_requests + 1;
      random_traffic(40);
      drain();
      random_traffic(310);

      drain();
      repeat (80) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
